// ----- src/ptt_pkg.sv -----
// Shared types and constants for the page table translator.
package ptt_pkg;

  localparam int VA_W      = 20;
  localparam int PA_W      = 18;
  localparam int IDX_W     = 6;
  localparam int FRAME_W   = 6;
  localparam int OP_W      = 3;
  localparam int ST_W      = 2;
  localparam int PAGE_SIZE = 4096;
  localparam int PAGE_BITS = $clog2(PAGE_SIZE);
  localparam int VPN_W     = VA_W - PAGE_BITS;

  localparam logic [VA_W-1:0] FAULT_NONE = '1;

  typedef enum logic [OP_W-1:0] {
    OP_READ      = 3'd0,
    OP_WRITE     = 3'd1,
    OP_MAP       = 3'd2,
    OP_CLEAR     = 3'd3,
    OP_CLEAR_ALL = 3'd4,
    OP_QUERY     = 3'd5
  } ptt_op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FAULT = 2'd2
  } ptt_status_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               accessed;
    logic               dirty;
  } ptt_entry_t;

  typedef struct packed {
    logic ram_we;
    logic set_valid;
    logic clr_valid;
    logic clr_all;
    logic fault;
  } ptt_ctl_t;

endpackage

// ----- src/page_table_translator_core.sv -----
// Page table translator top: input stage, table storage, result register.
// A single-level page table of NUM_PAGES entries translates 20-bit virtual
// addresses with 4 KiB pages into 18-bit physical addresses and also maps,
// clears, clears all and queries entries. One beat is taken every cycle
// while results drain. The accepting edge loads the input register and
// reads the entry RAM (frame, accessed, dirty), and the decoded result is
// registered when that beat advances out of the input stage. A result
// held by out_ready low stalls the input stage. Entry valid bits sit in
// flops, so clear all needs no sweep and none is needed after reset.
module page_table_translator_core #(
  parameter int NUM_PAGES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ptt_pkg::OP_W-1:0]    opcode,
  input  logic [ptt_pkg::VA_W-1:0]    virtual_address,
  input  logic [ptt_pkg::IDX_W-1:0]   page_index,
  input  logic [ptt_pkg::FRAME_W-1:0] frame,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ptt_pkg::ST_W-1:0]    status,
  output logic [ptt_pkg::PA_W-1:0]    physical_address,
  output logic                        entry_valid,
  output logic [ptt_pkg::FRAME_W-1:0] entry_frame,
  output logic                        entry_accessed,
  output logic                        entry_dirty,
  output logic [ptt_pkg::VA_W-1:0]    fault_address
);
  import ptt_pkg::*;

  localparam int AW   = $clog2(NUM_PAGES);
  localparam int VB_N = 1 << AW;
  localparam int EW   = $bits(ptt_entry_t);

  // Input stage
  logic               s1_valid;
  logic [OP_W-1:0]    s1_op;
  logic [VA_W-1:0]    s1_va;
  logic [IDX_W-1:0]   s1_idx;
  logic [FRAME_W-1:0] s1_fr;
  logic [AW-1:0]      s1_addr;

  logic               in_fire;
  logic               advance;
  logic [31:0]        in_page32;
  logic [31:0]        in_idx32;
  logic [31:0]        in_sel32;
  logic [AW-1:0]      in_addr;

  // Table storage
  logic [VB_N-1:0]    valid_bits;
  logic [EW-1:0]      ram_q;
  logic               byp_valid;
  logic [AW-1:0]      byp_addr;
  ptt_entry_t         byp_data;
  ptt_entry_t         rd_entry;
  logic [VA_W-1:0]    last_fault;
  logic [VA_W-1:0]    last_fault_next;

  // Decode results
  ptt_status_t        x_status;
  logic [PA_W-1:0]    x_pa;
  logic               x_qvalid;
  ptt_entry_t         x_qentry;
  ptt_ctl_t           x_ctl;
  ptt_entry_t         x_wdata;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign in_fire  = in_valid && in_ready;

  assign in_page32 = 32'(virtual_address[VA_W-1:PAGE_BITS]);
  assign in_idx32  = 32'(page_index);
  assign in_sel32  = (ptt_op_t'(opcode) == OP_READ || ptt_op_t'(opcode) == OP_WRITE)
                     ? in_page32 : in_idx32;
  assign in_addr   = in_sel32[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op   <= opcode;
      s1_va   <= virtual_address;
      s1_idx  <= page_index;
      s1_fr   <= frame;
      s1_addr <= in_addr;
    end
  end

  ptt_ram #(
    .WIDTH(EW),
    .DEPTH(NUM_PAGES)
  ) u_ram (
    .clk  (clk),
    .we   (advance && x_ctl.ram_we),
    .waddr(s1_addr),
    .wdata(x_wdata),
    .re   (in_fire),
    .raddr(in_addr),
    .rdata(ram_q)
  );

  // Forward the last write: it may land on the same edge as this beat's read.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (advance && x_ctl.ram_we) begin
      byp_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && x_ctl.ram_we) begin
      byp_addr <= s1_addr;
      byp_data <= x_wdata;
    end
  end

  assign rd_entry = (byp_valid && byp_addr == s1_addr) ? byp_data : ptt_entry_t'(ram_q);

  ptt_exec #(
    .NUM_PAGES(NUM_PAGES)
  ) u_exec (
    .op             (s1_op),
    .va             (s1_va),
    .idx            (s1_idx),
    .fr             (s1_fr),
    .entry          (rd_entry),
    .entry_valid_bit(valid_bits[s1_addr]),
    .status         (x_status),
    .pa             (x_pa),
    .q_valid        (x_qvalid),
    .q_entry        (x_qentry),
    .ctl            (x_ctl),
    .wdata          (x_wdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (advance) begin
      if (x_ctl.clr_all) begin
        valid_bits <= '0;
      end else if (x_ctl.clr_valid) begin
        valid_bits[s1_addr] <= 1'b0;
      end else if (x_ctl.set_valid) begin
        valid_bits[s1_addr] <= 1'b1;
      end
    end
  end

  assign last_fault_next = x_ctl.fault ? s1_va : last_fault;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_fault <= FAULT_NONE;
    end else if (advance) begin
      last_fault <= last_fault_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status           <= x_status;
      physical_address <= x_pa;
      entry_valid      <= x_qvalid;
      entry_frame      <= x_qentry.frame;
      entry_accessed   <= x_qentry.accessed;
      entry_dirty      <= x_qentry.dirty;
      fault_address    <= last_fault_next;
    end
  end

  a_fault_record: assert property (@(posedge clk) disable iff (rst)
    advance && x_ctl.fault |=> last_fault == $past(s1_va))
    else $error("fault address not recorded");

  a_clear_all: assert property (@(posedge clk) disable iff (rst)
    advance && x_ctl.clr_all |=> valid_bits == '0)
    else $error("clear all left a valid entry");

  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> physical_address == '0 && !entry_valid)
    else $error("error result carries payload");

  a_result_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FAULT |-> fault_address == last_fault)
    else $error("fault result does not show recorded address");

endmodule

// ----- src/ptt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/ptt_exec.sv -----
// Operation decode: result fields and table update for one registered beat.
module ptt_exec #(
  parameter int NUM_PAGES = 64
) (
  input  logic [ptt_pkg::OP_W-1:0]    op,
  input  logic [ptt_pkg::VA_W-1:0]    va,
  input  logic [ptt_pkg::IDX_W-1:0]   idx,
  input  logic [ptt_pkg::FRAME_W-1:0] fr,
  input  ptt_pkg::ptt_entry_t         entry,
  input  logic                        entry_valid_bit,
  output ptt_pkg::ptt_status_t        status,
  output logic [ptt_pkg::PA_W-1:0]    pa,
  output logic                        q_valid,
  output ptt_pkg::ptt_entry_t         q_entry,
  output ptt_pkg::ptt_ctl_t           ctl,
  output ptt_pkg::ptt_entry_t         wdata
);
  import ptt_pkg::*;

  logic [VPN_W-1:0] page;
  logic             page_ok;
  logic             idx_ok;
  ptt_entry_t       cur;

  assign page    = va[VA_W-1:PAGE_BITS];
  assign page_ok = 32'(page) < 32'(NUM_PAGES);
  assign idx_ok  = 32'(idx) < 32'(NUM_PAGES);
  // An unmapped entry always reads as all zero.
  assign cur     = entry_valid_bit ? entry : '0;

  always_comb begin
    status  = ST_OK;
    pa      = '0;
    q_valid = 1'b0;
    q_entry = '0;
    ctl     = '0;
    wdata   = cur;
    case (ptt_op_t'(op))
      OP_READ, OP_WRITE: begin
        if (!page_ok) begin
          status = ST_RANGE;
        end else if (!entry_valid_bit) begin
          status    = ST_FAULT;
          ctl.fault = 1'b1;
        end else begin
          pa         = PA_W'({cur.frame, va[PAGE_BITS-1:0]});
          ctl.ram_we = 1'b1;
          if (ptt_op_t'(op) == OP_READ) begin
            wdata.accessed = 1'b1;
          end else begin
            wdata.dirty = 1'b1;
          end
        end
      end
      OP_MAP: begin
        if (!idx_ok) begin
          status = ST_RANGE;
        end else begin
          // Keep accessed and dirty when remapping a live entry.
          ctl.ram_we    = 1'b1;
          ctl.set_valid = 1'b1;
          wdata.frame   = fr;
        end
      end
      OP_CLEAR: begin
        if (!idx_ok) begin
          status = ST_RANGE;
        end else begin
          ctl.clr_valid = 1'b1;
        end
      end
      OP_CLEAR_ALL: begin
        ctl.clr_all = 1'b1;
      end
      OP_QUERY: begin
        if (!idx_ok) begin
          status = ST_RANGE;
        end else begin
          q_valid = entry_valid_bit;
          q_entry = cur;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

endmodule

// ----- sim/tb_page_table_translator_core.sv -----
// Self-checking testbench for the page table translator core.
module tb_page_table_translator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ptt_pkg::*;

  localparam int TABLE_PAGES      = 64;
  localparam int RANDOM_PER_PHASE = 375;
  localparam int DRAIN_CYCLES     = 12;
  localparam int CYCLE_LIMIT      = 200000;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [PA_W-1:0]    phys;
    logic               ent_valid;
    logic [FRAME_W-1:0] ent_frame;
    logic               ent_accessed;
    logic               ent_dirty;
    logic [VA_W-1:0]    fault;
  } xlate_result_t;

  class translation_scoreboard;
    bit                 page_valid[TABLE_PAGES];
    logic [FRAME_W-1:0] page_frame[TABLE_PAGES];
    bit                 page_accessed[TABLE_PAGES];
    bit                 page_dirty[TABLE_PAGES];
    logic [VA_W-1:0]    last_fault;
    xlate_result_t      pending_results[$];
    int                 failures;

    function new();
      for (int i = 0; i < TABLE_PAGES; i++) wipe_page(i);
      last_fault = FAULT_NONE;
      failures   = 0;
    endfunction

    function void wipe_page(int p);
      page_valid[p]    = 1'b0;
      page_frame[p]    = '0;
      page_accessed[p] = 1'b0;
      page_dirty[p]    = 1'b0;
    endfunction

    // Apply one accepted beat to the table and queue the result it produces.
    function void note_beat(logic [OP_W-1:0] op, logic [VA_W-1:0] va,
                            logic [IDX_W-1:0] idx, logic [FRAME_W-1:0] fr);
      xlate_result_t res;
      int unsigned   vpn;
      int unsigned   offset;
      res    = '0;
      vpn    = va >> PAGE_BITS;
      offset = va % PAGE_SIZE;
      case (op)
        OP_READ, OP_WRITE: begin
          if (vpn >= TABLE_PAGES) begin
            res.status = ST_RANGE;
          end else if (!page_valid[vpn]) begin
            last_fault = va;
            res.status = ST_FAULT;
          end else begin
            res.status = ST_OK;
            res.phys   = PA_W'(int'(page_frame[vpn]) * PAGE_SIZE + offset);
            if (op == OP_READ) page_accessed[vpn] = 1'b1;
            else page_dirty[vpn] = 1'b1;
          end
        end
        OP_MAP, OP_CLEAR, OP_QUERY: begin
          if (idx >= TABLE_PAGES) begin
            res.status = ST_RANGE;
          end else if (op == OP_MAP) begin
            // remap keeps accessed and dirty
            page_valid[idx] = 1'b1;
            page_frame[idx] = fr;
          end else if (op == OP_CLEAR) begin
            wipe_page(idx);
          end else begin
            res.ent_valid    = page_valid[idx];
            res.ent_frame    = page_frame[idx];
            res.ent_accessed = page_accessed[idx];
            res.ent_dirty    = page_dirty[idx];
          end
        end
        OP_CLEAR_ALL: begin
          for (int i = 0; i < TABLE_PAGES; i++) wipe_page(i);
        end
        default: ;
      endcase
      res.fault = last_fault;
      pending_results.push_back(res);
    endfunction

    function void compare_field(string field_name, longint unsigned want,
                                longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, field_name, want, got);
        failures++;
      end
    endfunction

    function void check_result(xlate_result_t got);
      xlate_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %p", $time, got);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status",           want.status,       got.status);
      compare_field("physical_address", want.phys,         got.phys);
      compare_field("entry_valid",      want.ent_valid,    got.ent_valid);
      compare_field("entry_frame",      want.ent_frame,    got.ent_frame);
      compare_field("entry_accessed",   want.ent_accessed, got.ent_accessed);
      compare_field("entry_dirty",      want.ent_dirty,    got.ent_dirty);
      compare_field("fault_address",    want.fault,        got.fault);
    endfunction
  endclass

  logic               clk             = 1'b0;
  logic               rst             = 1'b1;
  logic               in_valid        = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    opcode          = '0;
  logic [VA_W-1:0]    virtual_address = '0;
  logic [IDX_W-1:0]   page_index      = '0;
  logic [FRAME_W-1:0] frame           = '0;
  logic               out_valid;
  logic               out_ready       = 1'b0;
  logic [ST_W-1:0]    status;
  logic [PA_W-1:0]    physical_address;
  logic               entry_valid;
  logic [FRAME_W-1:0] entry_frame;
  logic               entry_accessed;
  logic               entry_dirty;
  logic [VA_W-1:0]    fault_address;

  translation_scoreboard sb;
  int send_idle_pct = 34;
  int recv_idle_pct = 69;
  int cycle_count   = 0;

  page_table_translator_core #(
    .NUM_PAGES(TABLE_PAGES)
  ) u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .opcode           (opcode),
    .virtual_address  (virtual_address),
    .page_index       (page_index),
    .frame            (frame),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .physical_address (physical_address),
    .entry_valid      (entry_valid),
    .entry_frame      (entry_frame),
    .entry_accessed   (entry_accessed),
    .entry_dirty      (entry_dirty),
    .fault_address    (fault_address)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      sb.note_beat(opcode, virtual_address, page_index, frame);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result('{status, physical_address, entry_valid, entry_frame,
                        entry_accessed, entry_dirty, fault_address});
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_page_table_translator_core NOT OK");
      $finish;
    end
  end

  // Present one beat after a random gap and hold it until accepted.
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [VA_W-1:0] va,
                           input logic [IDX_W-1:0] idx, input logic [FRAME_W-1:0] fr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    opcode          <= op;
    virtual_address <= va;
    page_index      <= idx;
    frame           <= fr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Favor a small working set so accesses mostly hit mapped pages.
  function automatic int unsigned pick_page();
    return ($urandom_range(3) != 0) ? $urandom_range(15) : $urandom_range(TABLE_PAGES - 1);
  endfunction

  task automatic send_random_beat();
    int unsigned      pick;
    logic [OP_W-1:0]  op;
    logic [VA_W-1:0]  va;
    pick = $urandom_range(999);
    if (pick < 300)      op = OP_READ;
    else if (pick < 550) op = OP_WRITE;
    else if (pick < 750) op = OP_MAP;
    else if (pick < 810) op = OP_CLEAR;
    else if (pick < 815) op = OP_CLEAR_ALL;
    else if (pick < 950) op = OP_QUERY;
    else                 op = ($urandom_range(1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
    if ($urandom_range(9) < 8) begin
      va = VA_W'((pick_page() << PAGE_BITS) | $urandom_range(PAGE_SIZE - 1));
    end else begin
      va = VA_W'($urandom_range(2**VA_W - 1));
    end
    send_beat(op, va, IDX_W'(pick_page()), FRAME_W'($urandom_range(2**FRAME_W - 1)));
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: faults, range edges, offsets, remap, clears, spare opcodes
    send_beat(OP_READ,      20'h00000, 6'd0,  6'd0);
    send_beat(OP_WRITE,     20'hFFFFF, 6'd63, 6'd63);
    send_beat(OP_READ,      20'h40000, 6'd0,  6'd0);
    send_beat(OP_WRITE,     20'h3FFFF, 6'd0,  6'd0);
    send_beat(OP_MAP,       20'h00000, 6'd0,  6'd63);
    send_beat(OP_MAP,       20'hFFFFF, 6'd63, 6'd0);
    send_beat(OP_READ,      20'h00FFF, 6'd0,  6'd0);
    send_beat(OP_WRITE,     20'h00000, 6'd0,  6'd0);
    send_beat(OP_QUERY,     20'h00000, 6'd0,  6'd0);
    send_beat(OP_MAP,       20'h00000, 6'd0,  6'd21);
    send_beat(OP_QUERY,     20'h00000, 6'd0,  6'd0);
    send_beat(OP_WRITE,     20'h3F123, 6'd0,  6'd0);
    send_beat(OP_QUERY,     20'h00000, 6'd63, 6'd0);
    send_beat(OP_CLEAR,     20'h00000, 6'd0,  6'd0);
    send_beat(OP_QUERY,     20'h00000, 6'd0,  6'd0);
    send_beat(OP_READ,      20'h00010, 6'd0,  6'd0);
    send_beat(OP_SPARE_LO,  20'hFFFFF, 6'd63, 6'd63);
    send_beat(OP_SPARE_HI,  20'h00000, 6'd0,  6'd0);
    send_beat(OP_MAP,       20'h00000, 6'd42, 6'd42);
    send_beat(OP_READ,      20'h2A555, 6'd0,  6'd0);
    send_beat(OP_CLEAR_ALL, 20'hFFFFF, 6'd63, 6'd63);
    send_beat(OP_QUERY,     20'h00000, 6'd63, 6'd0);
    send_beat(OP_QUERY,     20'h00000, 6'd42, 6'd0);
    send_beat(OP_READ,      20'h3F000, 6'd0,  6'd0);

    repeat (RANDOM_PER_PHASE) send_random_beat();
    send_idle_pct = 69;
    recv_idle_pct = 34;
    repeat (RANDOM_PER_PHASE) send_random_beat();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (RANDOM_PER_PHASE) send_random_beat();
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("tb_page_table_translator_core OK");
    end else begin
      $display("tb_page_table_translator_core NOT OK");
    end
    $finish;
  end

endmodule
